// File: rtl/lz77_token_decoder_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef LZ77_TOKEN_DECODER_MACROS_SVH
`define LZ77_TOKEN_DECODER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define LZD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzd: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define LZD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzd: next-cycle check failed");

`endif

// File: rtl/lzd_pkg.sv
package lzd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int BW_W         = WIN_AW + 1;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = $clog2(Q_DEPTH);
    localparam int Q_CW         = Q_AW + 1;

    typedef logic [BW_W-1:0]   bw_t;
    typedef logic [WIN_AW-1:0] win_addr_t;
    typedef logic [Q_AW-1:0]   q_addr_t;
    typedef logic [Q_CW-1:0]   q_count_t;

    localparam bw_t WIN_FULL = bw_t'(WINDOW_DEPTH);

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_OFFLOW  = 2'd1,
        PH_NEXT    = 2'd2,
        PH_LITERAL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CMD_LIT  = 2'd0,
        CMD_COPY = 2'd1,
        CMD_END  = 2'd2,
        CMD_ERR  = 2'd3
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_COPY = 2'd1,
        BK_END  = 2'd2
    } back_state_t;

    typedef struct packed {
        cmd_op_t   op;
        logic      with_byte;
        logic [7:0] data;
        logic [3:0] len;
        win_addr_t off;
    } cmd_t;

endpackage

// File: rtl/lzd_front.sv
module lzd_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,
    input  logic          s_axis_tlast,
    input  logic          q_full,
    output logic          push,
    output lzd_pkg::cmd_t cmd
);

    lzd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      len_reg, len_next;
    logic [3:0]      offh_reg, offh_next;
    logic [7:0]      pend_reg, pend_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            disc_reg, disc_next;
    lzd_pkg::bw_t    bw_reg, bw_next;

    logic                 accept;
    lzd_pkg::win_addr_t   off_full;
    logic                 off_bad;
    logic [3:0]           inc;
    lzd_pkg::bw_t         bw_sum;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign off_full      = {offh_reg, s_axis_tdata};
    assign off_bad       = (off_full == '0) || (lzd_pkg::bw_t'(off_full) > bw_reg);

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                phase_next = lzd_pkg::PH_HEADER;
            end
            else if (!disc_reg)
            begin
                case (phase_reg)
                    lzd_pkg::PH_HEADER:
                    begin
                        phase_next = (s_axis_tdata[7:4] != 4'h0) ? lzd_pkg::PH_OFFLOW
                                                                : lzd_pkg::PH_LITERAL;
                    end
                    lzd_pkg::PH_OFFLOW:
                    begin
                        phase_next = off_bad ? phase_reg : lzd_pkg::PH_NEXT;
                    end
                    default:
                    begin
                        phase_next = lzd_pkg::PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        len_next        = len_reg;
        offh_next       = offh_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        disc_next       = disc_reg;
        inc             = 4'd0;
        push            = 1'b0;
        cmd             = '0;
        cmd.op          = lzd_pkg::CMD_LIT;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                if (!disc_reg)
                begin
                    push = 1'b1;
                    if (phase_reg != lzd_pkg::PH_HEADER)
                    begin
                        cmd.op = lzd_pkg::CMD_ERR;
                    end
                    else
                    begin
                        cmd.op        = lzd_pkg::CMD_END;
                        cmd.with_byte = (s_axis_tdata == 8'h00) && pend_valid_reg;
                        cmd.data      = pend_reg;
                    end
                end
                len_next        = 4'd0;
                offh_next       = 4'd0;
                pend_next       = 8'h00;
                pend_valid_next = 1'b0;
                disc_next       = 1'b0;
            end
            else if (!disc_reg)
            begin
                case (phase_reg)
                    lzd_pkg::PH_HEADER:
                    begin
                        if (pend_valid_reg)
                        begin
                            push     = 1'b1;
                            cmd.op   = lzd_pkg::CMD_LIT;
                            cmd.data = pend_reg;
                            inc      = 4'd1;
                        end
                        pend_valid_next = 1'b0;
                        len_next        = s_axis_tdata[7:4];
                        offh_next       = s_axis_tdata[3:0];
                    end
                    lzd_pkg::PH_OFFLOW:
                    begin
                        push = 1'b1;
                        if (off_bad)
                        begin
                            cmd.op    = lzd_pkg::CMD_ERR;
                            disc_next = 1'b1;
                        end
                        else
                        begin
                            cmd.op  = lzd_pkg::CMD_COPY;
                            cmd.len = len_reg;
                            cmd.off = off_full;
                            inc     = len_reg;
                        end
                    end
                    default:
                    begin
                        pend_next       = s_axis_tdata;
                        pend_valid_next = 1'b1;
                    end
                endcase
            end
        end
    end

    assign bw_sum = bw_reg + lzd_pkg::bw_t'(inc);

    always_comb
    begin
        if (accept && s_axis_tlast)
        begin
            bw_next = '0;
        end
        else if (bw_sum > lzd_pkg::WIN_FULL)
        begin
            bw_next = lzd_pkg::WIN_FULL;
        end
        else
        begin
            bw_next = bw_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= lzd_pkg::PH_HEADER;
            len_reg        <= 4'd0;
            offh_reg       <= 4'd0;
            pend_reg       <= 8'h00;
            pend_valid_reg <= 1'b0;
            disc_reg       <= 1'b0;
            bw_reg         <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            len_reg        <= len_next;
            offh_reg       <= offh_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            disc_reg       <= disc_next;
            bw_reg         <= bw_next;
        end
    end

    `include "lz77_token_decoder_macros.svh"

    `LZD_ASSERT_SAME(a_bw_bound, 1'b1, bw_reg <= lzd_pkg::WIN_FULL)
    `LZD_ASSERT_NEXT(a_last_restarts, accept && s_axis_tlast, !disc_reg && !pend_valid_reg && bw_reg == '0)

endmodule

// File: rtl/lzd_queue.sv
module lzd_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lzd_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output lzd_pkg::cmd_t head_cmd
);

    lzd_pkg::cmd_t          slot_reg [lzd_pkg::Q_DEPTH];
    lzd_pkg::q_addr_t       wr_ptr_reg, wr_ptr_next;
    lzd_pkg::q_addr_t       rd_ptr_reg, rd_ptr_next;
    lzd_pkg::q_count_t      count_reg, count_next;

    assign full       = (count_reg == lzd_pkg::q_count_t'(lzd_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + lzd_pkg::q_addr_t'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + lzd_pkg::q_addr_t'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + lzd_pkg::q_count_t'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - lzd_pkg::q_count_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `include "lz77_token_decoder_macros.svh"

    `LZD_ASSERT_SAME(a_no_overflow, push, !full || pop)
    `LZD_ASSERT_SAME(a_no_underflow, pop, head_valid)

endmodule

// File: rtl/lzd_back.sv
module lzd_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  lzd_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,
    output logic [1:0]    m_axis_tuser,
    output logic          m_axis_tlast
);

    lzd_pkg::back_state_t state_reg, state_next;

    logic [7:0]          hist_mem [lzd_pkg::WINDOW_DEPTH];
    logic [7:0]          rd_data_reg;
    lzd_pkg::win_addr_t  wp_reg, wp_next;
    lzd_pkg::win_addr_t  src_reg, src_next;
    lzd_pkg::win_addr_t  off_reg, off_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                first_reg, first_next;
    logic [7:0]          prev_reg, prev_next;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    lzd_pkg::kind_t      out_kind_reg, out_kind_next;
    logic                out_last_reg, out_last_next;

    logic                slot_free;
    logic                wr_en;
    logic [7:0]          wr_data;
    logic                rd_en;
    lzd_pkg::win_addr_t  rd_addr;
    logic [7:0]          copy_byte;
    logic                copy_issue;

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign copy_byte = (first_reg || off_reg != lzd_pkg::win_addr_t'(1)) ? rd_data_reg
                                                                        : prev_reg;
    assign copy_issue = (state_reg == lzd_pkg::BK_IDLE) && pop
                        && (head_cmd.op == lzd_pkg::CMD_COPY);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lzd_pkg::BK_IDLE:
            begin
                if (head_valid)
                begin
                    if (head_cmd.op == lzd_pkg::CMD_COPY)
                    begin
                        state_next = lzd_pkg::BK_COPY;
                    end
                    else if (head_cmd.op == lzd_pkg::CMD_END && head_cmd.with_byte && slot_free)
                    begin
                        state_next = lzd_pkg::BK_END;
                    end
                end
            end
            lzd_pkg::BK_COPY:
            begin
                if (slot_free && cnt_reg == 4'd1)
                begin
                    state_next = lzd_pkg::BK_IDLE;
                end
            end
            lzd_pkg::BK_END:
            begin
                if (slot_free)
                begin
                    state_next = lzd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lzd_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        wr_en          = 1'b0;
        wr_data        = 8'h00;
        rd_en          = 1'b0;
        rd_addr        = src_reg;
        wp_next        = wp_reg;
        src_next       = src_reg;
        off_next       = off_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            lzd_pkg::BK_IDLE:
            begin
                if (head_valid)
                begin
                    case (head_cmd.op)
                        lzd_pkg::CMD_COPY:
                        begin
                            pop        = 1'b1;
                            rd_en      = 1'b1;
                            rd_addr    = wp_reg - head_cmd.off;
                            src_next   = wp_reg - head_cmd.off + lzd_pkg::win_addr_t'(1);
                            off_next   = head_cmd.off;
                            cnt_next   = head_cmd.len;
                            first_next = 1'b1;
                        end
                        lzd_pkg::CMD_LIT:
                        begin
                            if (slot_free)
                            begin
                                pop            = 1'b1;
                                wr_en          = 1'b1;
                                wr_data        = head_cmd.data;
                                out_valid_next = 1'b1;
                                out_byte_next  = head_cmd.data;
                                out_kind_next  = lzd_pkg::KIND_DATA;
                                out_last_next  = 1'b1;
                            end
                        end
                        lzd_pkg::CMD_END:
                        begin
                            if (slot_free)
                            begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                if (head_cmd.with_byte)
                                begin
                                    wr_en         = 1'b1;
                                    wr_data       = head_cmd.data;
                                    out_byte_next = head_cmd.data;
                                    out_kind_next = lzd_pkg::KIND_DATA;
                                    out_last_next = 1'b0;
                                end
                                else
                                begin
                                    out_byte_next = 8'h00;
                                    out_kind_next = lzd_pkg::KIND_END;
                                    out_last_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            if (slot_free)
                            begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                out_byte_next  = 8'h00;
                                out_kind_next  = lzd_pkg::KIND_ERR;
                                out_last_next  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            lzd_pkg::BK_COPY:
            begin
                if (slot_free)
                begin
                    wr_en          = 1'b1;
                    wr_data        = copy_byte;
                    out_valid_next = 1'b1;
                    out_byte_next  = copy_byte;
                    out_kind_next  = lzd_pkg::KIND_DATA;
                    out_last_next  = (cnt_reg == 4'd1);
                    cnt_next       = cnt_reg - 4'd1;
                    first_next     = 1'b0;
                    if (cnt_reg != 4'd1)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = src_reg;
                        src_next = src_reg + lzd_pkg::win_addr_t'(1);
                    end
                end
            end
            lzd_pkg::BK_END:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'h00;
                    out_kind_next  = lzd_pkg::KIND_END;
                    out_last_next  = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_axis_tready;
            end
        endcase
        if (wr_en)
        begin
            wp_next   = wp_reg + lzd_pkg::win_addr_t'(1);
            prev_next = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wp_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        off_reg      <= off_next;
        prev_reg     <= prev_next;
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzd_pkg::BK_IDLE;
            wp_reg        <= '0;
            cnt_reg       <= 4'd0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    `include "lz77_token_decoder_macros.svh"

    `LZD_ASSERT_SAME(a_copy_count, state_reg == lzd_pkg::BK_COPY, cnt_reg != 4'd0)
    `LZD_ASSERT_NEXT(a_copy_entry, copy_issue, state_reg == lzd_pkg::BK_COPY && first_reg)

endmodule

// File: rtl/lz77_token_decoder.sv
// Channel  | Direction | tdata (low bit up) | tuser      | tlast
// s_axis   | in        | in_byte[7:0]       | -          | in_last (flag byte)
// m_axis   | out       | out_byte[7:0]      | kind[1:0]  | run_last
//
// Input side takes one byte a cycle while the four-entry command queue has room.
// Literal, end and error results leave at one a cycle, and copies at one byte a cycle
// through the history RAM port after the first read, whenever the output slot is free.
// Reset clears all control state at once; no clearing pass on the 4096-byte history.
// Output stalls fill the queue and then hold off input; input gaps drain the queue.
module lz77_token_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte[7:0]
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte[7:0]
    output logic [1:0] m_axis_tuser,   // kind[1:0]
    output logic       m_axis_tlast
);

    logic          push;
    lzd_pkg::cmd_t push_cmd;
    logic          pop;
    logic          q_full;
    logic          head_valid;
    lzd_pkg::cmd_t head_cmd;

    lzd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    lzd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    lzd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
